### hw/rtl/plucked_string_synth_core_assert.svh
// Assertion macros shared by the plucked string voice RTL.
// Used by pss_voice and pss_obuf; compiled out when SYNTHESIS is defined.
`ifndef PLUCKED_STRING_SYNTH_CORE_ASSERT_SVH
`define PLUCKED_STRING_SYNTH_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define PSS_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pss assertion failed");

// Condition must never be seen at a clock edge outside reset.
`define PSS_ASSERT_NEVER(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("pss forbidden condition seen");

`else

`define PSS_ASSERT(name, clk, rst_n, prop)
`define PSS_ASSERT_NEVER(name, clk, rst_n, cond)

`endif

`endif

### hw/rtl/pss_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and register codes for the plucked string voice.
// No dependencies; pss_if, pss_cfg, pss_voice, pss_obuf and the top level import this package.
package pss_pkg;

    localparam int MAX_PERIOD    = 1024;
    localparam int SAMPLE_BITS   = 16;
    localparam int ADDR_BITS     = $clog2(MAX_PERIOD);
    localparam int PERIOD_BITS   = 11;
    localparam int GAIN_BITS     = 16;
    localparam int THR_BITS      = 15;
    localparam int HOLD_BITS     = 20;
    localparam int ELAPSED_BITS  = 21;

    localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = '1;

    // Item function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // APB register map, one 32-bit word per register
    localparam int APB_DATA_BITS = 32;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_ADDR_BITS = CFG_IDX_BITS + 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_PERIOD    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DECAY     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_LEVEL     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_HOLD      = 3'd4;

    localparam logic [PERIOD_BITS-1:0] RST_PERIOD    = 11'd583;
    localparam logic [GAIN_BITS-1:0]   RST_DECAY     = 16'd65437;
    localparam logic [GAIN_BITS-1:0]   RST_LEVEL     = 16'd13107;
    localparam logic [THR_BITS-1:0]    RST_THRESHOLD = 15'd1;
    localparam logic [HOLD_BITS-1:0]   RST_HOLD      = 20'd192000;

    // Result buffer
    localparam int OBUF_DEPTH = 4;
    localparam int OBUF_AW    = $clog2(OBUF_DEPTH);
    localparam int OBUF_CW    = OBUF_AW + 1;

    typedef struct packed {
        logic [PERIOD_BITS-1:0] period_length;
        logic [GAIN_BITS-1:0]   decay_gain;
        logic [GAIN_BITS-1:0]   output_level;
        logic [THR_BITS-1:0]    silence_threshold;
        logic [HOLD_BITS-1:0]   hold_samples;
    } t_cfg;

    typedef struct packed {
        logic                          func;
        logic [ADDR_BITS-1:0]          entry_index;
        logic signed [SAMPLE_BITS-1:0] excitation;
    } t_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          active;
    } t_result;

endpackage

### hw/rtl/pss_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for voice items and results.
// Depends on pss_pkg for field widths.
interface pss_in_if import pss_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [ADDR_BITS-1:0]          entry_index;
    logic signed [SAMPLE_BITS-1:0] excitation;

    modport source (output valid, func, entry_index, excitation, input ready);
    modport sink   (input valid, func, entry_index, excitation, output ready);
endinterface

interface pss_out_if import pss_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          active;

    modport source (output valid, sample_out, active, input ready);
    modport sink   (input valid, sample_out, active, output ready);
endinterface

### hw/rtl/plucked_string_synth_core.sv
`timescale 1ns / 1ps
// Top level of the plucked string voice: item channel, result channel and APB registers.
// Depends on pss_pkg, pss_if, pss_cfg, pss_voice and pss_obuf.

// One Karplus-Strong string voice. The block takes one item per clock cycle: a load
// writes an excitation sample into the 1024-entry delay store and restarts the voice,
// a tick reads the entry at the read position, writes back the decayed two-point
// average unless the voice has stopped and returns one scaled output sample. Each item
// addresses the single-port-read delay store RAM at its transfer and passes the filter
// and multipliers as the read data arrives; a tick's result is registered in the result
// queue, a four-entry buffer; the item channel drops ready only while that buffer is
// backed up by the result channel. The store has no reset: load every entry of the
// active period before ticking. Write registers only while the voice is idle.
module plucked_string_synth_core import pss_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    pss_in_if.sink                   i_in,
    pss_out_if.source                o_out,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    t_cfg                cfg;
    t_item               item;
    t_result             result;
    logic                accept;
    logic                s1_tick;
    logic                push;
    logic [OBUF_CW-1:0]  obuf_count;
    logic [OBUF_CW:0]    pending;

    pss_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // A tick in flight still needs a buffer slot next cycle
    assign pending    = (OBUF_CW + 1)'(obuf_count) + (OBUF_CW + 1)'(s1_tick);
    assign i_in.ready = (pending <= (OBUF_CW + 1)'(OBUF_DEPTH - 1));
    assign accept     = i_in.valid && i_in.ready;

    assign item.func        = i_in.func;
    assign item.entry_index = i_in.entry_index;
    assign item.excitation  = i_in.excitation;

    pss_voice u_voice (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_accept  (accept),
        .i_item    (item),
        .o_s1_tick (s1_tick),
        .o_push    (push),
        .o_result  (result)
    );

    pss_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (result),
        .o_count (obuf_count),
        .o_out   (o_out)
    );

endmodule

### hw/rtl/pss_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module pss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/pss_cfg.sv
`timescale 1ns / 1ps
// APB register file holding the voice configuration.
// Depends on pss_pkg for the register map and the t_cfg struct.
module pss_cfg import pss_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output t_cfg                     o_cfg
);

    t_cfg                    r_cfg, n_cfg;
    logic [CFG_IDX_BITS-1:0] reg_idx;
    logic                    wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_ADDR_BITS-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_PERIOD:    n_cfg.period_length     = pwdata[PERIOD_BITS-1:0];
                REG_DECAY:     n_cfg.decay_gain        = pwdata[GAIN_BITS-1:0];
                REG_LEVEL:     n_cfg.output_level      = pwdata[GAIN_BITS-1:0];
                REG_THRESHOLD: n_cfg.silence_threshold = pwdata[THR_BITS-1:0];
                REG_HOLD:      n_cfg.hold_samples      = pwdata[HOLD_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PERIOD:    prdata = APB_DATA_BITS'(r_cfg.period_length);
            REG_DECAY:     prdata = APB_DATA_BITS'(r_cfg.decay_gain);
            REG_LEVEL:     prdata = APB_DATA_BITS'(r_cfg.output_level);
            REG_THRESHOLD: prdata = APB_DATA_BITS'(r_cfg.silence_threshold);
            REG_HOLD:      prdata = APB_DATA_BITS'(r_cfg.hold_samples);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period_length     <= RST_PERIOD;
            r_cfg.decay_gain        <= RST_DECAY;
            r_cfg.output_level      <= RST_LEVEL;
            r_cfg.silence_threshold <= RST_THRESHOLD;
            r_cfg.hold_samples      <= RST_HOLD;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hw/rtl/pss_voice.sv
`timescale 1ns / 1ps
// String voice datapath: read position, delay store read-modify-write and decay filter.
// Depends on pss_pkg, pss_ram and the assertion macro header.
`include "plucked_string_synth_core_assert.svh"

module pss_voice import pss_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_accept,
    input  t_item   i_item,
    output logic    o_s1_tick,
    output logic    o_push,
    output t_result o_result
);

    localparam int FILT_SHIFT  = 17;
    localparam int OUT_SHIFT   = 16;
    localparam int FPROD_BITS  = SAMPLE_BITS + 1 + GAIN_BITS + 1;
    localparam int OPROD_BITS  = SAMPLE_BITS + GAIN_BITS + 1;

    // Read position, updated at accept
    logic [ADDR_BITS-1:0]          r_pos, n_pos;
    logic [PERIOD_BITS-1:0]        eff_period;
    logic [PERIOD_BITS-1:0]        pos_inc;

    // Second stage: item whose store data is arriving
    logic                          r_s1_valid;
    logic                          r_s1_func;
    logic [ADDR_BITS-1:0]          r_s1_addr;
    logic signed [SAMPLE_BITS-1:0] r_s1_exc;

    // Write that landed at the same edge as the stage's read
    logic                          r_fwd_valid;
    logic [ADDR_BITS-1:0]          r_fwd_addr;
    logic signed [SAMPLE_BITS-1:0] r_fwd_data;

    logic signed [SAMPLE_BITS-1:0] r_prev, n_prev;
    logic [ELAPSED_BITS-1:0]       r_elapsed, n_elapsed;
    logic                          r_stopped, n_stopped;

    logic                          ram_we;
    logic [ADDR_BITS-1:0]          ram_waddr;
    logic [SAMPLE_BITS-1:0]        ram_wdata;
    logic [SAMPLE_BITS-1:0]        ram_rdata;

    logic signed [SAMPLE_BITS-1:0] cur;
    logic signed [SAMPLE_BITS:0]   cur_x;
    logic signed [SAMPLE_BITS:0]   pair_sum;
    logic signed [FPROD_BITS-1:0]  fprod;
    logic [FPROD_BITS-1:0]         fbias;
    logic signed [OPROD_BITS-1:0]  oprod;
    logic [OPROD_BITS-1:0]         obias;
    logic signed [SAMPLE_BITS-1:0] filt;
    logic signed [SAMPLE_BITS-1:0] outv;
    logic [SAMPLE_BITS:0]          mag;
    logic                          stop_now;
    logic                          s1_load;
    logic                          s1_live_tick;

    pss_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_PERIOD)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_pos),
        .o_rdata (ram_rdata)
    );

    // Clamp the period into the store range
    always_comb begin
        if (i_cfg.period_length < PERIOD_BITS'(2)) begin
            eff_period = PERIOD_BITS'(2);
        end else if (i_cfg.period_length > PERIOD_BITS'(MAX_PERIOD)) begin
            eff_period = PERIOD_BITS'(MAX_PERIOD);
        end else begin
            eff_period = i_cfg.period_length;
        end
    end

    assign pos_inc = PERIOD_BITS'(r_pos) + PERIOD_BITS'(1);

    // Advance even if the voice turns out stopped: a load restarts the position anyway
    always_comb begin
        n_pos = r_pos;
        if (i_accept) begin
            if (i_item.func == FUNC_LOAD) begin
                n_pos = '0;
            end else if (pos_inc >= eff_period) begin
                n_pos = '0;
            end else begin
                n_pos = pos_inc[ADDR_BITS-1:0];
            end
        end
    end

    // Forward a write that hit the entry during its read
    assign cur = (r_fwd_valid && (r_fwd_addr == r_s1_addr)) ? r_fwd_data : ram_rdata;

    assign s1_load      = r_s1_valid && (r_s1_func == FUNC_LOAD);
    assign s1_live_tick = r_s1_valid && (r_s1_func == FUNC_TICK) && !r_stopped;

    assign pair_sum = SAMPLE_BITS'(0) + cur + r_prev;
    assign fprod    = pair_sum * $signed({1'b0, i_cfg.decay_gain});
    assign oprod    = cur * $signed({1'b0, i_cfg.output_level});

    // Bias negative products so the shift truncates toward zero
    assign fbias = fprod + (fprod[FPROD_BITS-1] ? FPROD_BITS'((1 << FILT_SHIFT) - 1) : '0);
    assign obias = oprod + (oprod[OPROD_BITS-1] ? OPROD_BITS'((1 << OUT_SHIFT) - 1) : '0);
    assign filt  = fbias[FILT_SHIFT +: SAMPLE_BITS];
    assign outv  = obias[OUT_SHIFT +: SAMPLE_BITS];

    assign cur_x    = {cur[SAMPLE_BITS-1], cur};
    assign mag      = cur_x[SAMPLE_BITS] ? (~cur_x + 1'b1) : cur_x;
    assign stop_now = (r_elapsed > ELAPSED_BITS'(i_cfg.hold_samples))
                   && (mag < (SAMPLE_BITS + 1)'(i_cfg.silence_threshold));

    assign ram_we    = s1_load || s1_live_tick;
    assign ram_waddr = r_s1_addr;
    assign ram_wdata = s1_load ? r_s1_exc : filt;

    always_comb begin
        n_prev    = r_prev;
        n_elapsed = r_elapsed;
        n_stopped = r_stopped;
        if (s1_load) begin
            n_prev    = '0;
            n_elapsed = '0;
            n_stopped = 1'b0;
        end else if (s1_live_tick) begin
            n_prev    = cur;
            n_stopped = stop_now;
            if (r_elapsed != ELAPSED_MAX) begin
                n_elapsed = r_elapsed + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_prev      <= '0;
            r_elapsed   <= '0;
            r_stopped   <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_s1_valid  <= i_accept;
            r_fwd_valid <= ram_we;
            r_prev      <= n_prev;
            r_elapsed   <= n_elapsed;
            r_stopped   <= n_stopped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_func <= i_item.func;
            r_s1_addr <= (i_item.func == FUNC_LOAD) ? i_item.entry_index : r_pos;
            r_s1_exc  <= i_item.excitation;
        end
        r_fwd_addr <= ram_waddr;
        r_fwd_data <= ram_wdata;
    end

    assign o_s1_tick           = r_s1_valid && (r_s1_func == FUNC_TICK);
    assign o_push              = o_s1_tick;
    assign o_result.sample_out = r_stopped ? '0 : outv;
    assign o_result.active     = !r_stopped && !stop_now;

    `PSS_ASSERT(a_load_restarts, i_clk, i_rst_n,
        s1_load |=> (!r_stopped && r_elapsed == '0 && r_prev == '0))
    `PSS_ASSERT(a_stop_sticks, i_clk, i_rst_n,
        (r_stopped && !s1_load) |=> r_stopped)
    `PSS_ASSERT(a_load_rewinds, i_clk, i_rst_n,
        (i_accept && i_item.func == FUNC_LOAD) |=> (r_pos == '0))

endmodule

### hw/rtl/pss_obuf.sv
`timescale 1ns / 1ps
// Small result queue that decouples the voice from the result channel.
// Depends on pss_pkg, pss_if and the assertion macro header.
`include "plucked_string_synth_core_assert.svh"

module pss_obuf import pss_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  t_result              i_data,
    output logic [OBUF_CW-1:0]   o_count,
    pss_out_if.source            o_out
);

    t_result              r_mem [OBUF_DEPTH];
    logic [OBUF_AW-1:0]   r_wr, r_rd;
    logic [OBUF_CW-1:0]   r_count, n_count;
    logic                 pop;

    assign pop = o_out.valid && o_out.ready;

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_count          = r_count;
    assign o_out.valid      = (r_count != '0);
    assign o_out.sample_out = r_mem[r_rd].sample_out;
    assign o_out.active     = r_mem[r_rd].active;

    `PSS_ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n,
        i_push && !pop && (r_count == OBUF_CW'(OBUF_DEPTH)))
    `PSS_ASSERT(a_count_holds, i_clk, i_rst_n,
        (!i_push && !pop) |=> $stable(r_count))
    `PSS_ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n,
        pop && (r_count == '0))

endmodule

### tb/tb_plucked_string_synth_core.sv
`timescale 1ns / 1ps
// Self-checking bench for plucked_string_synth_core: load/tick items in, scaled samples out.
// Depends on pss_pkg and pss_if from the RTL; predicts each tick result in a scoreboard class.

module tb_plucked_string_synth_core;
    import pss_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_ITEMS = 800;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 12;
    localparam int TIMEOUT_NS   = 5_000_000;

    typedef enum {RX_OPEN, RX_COIN, RX_THIRD, RX_MOSTLY} t_rx_mode;

    // Voice state copy plus the queue of samples the block still owes us.
    class voice_scoreboard;
        t_cfg                          cfg;
        logic signed [SAMPLE_BITS-1:0] delay_line [MAX_PERIOD];
        logic [ADDR_BITS-1:0]          rd_pos;
        logic signed [SAMPLE_BITS-1:0] prev_sample;
        logic [ELAPSED_BITS-1:0]       elapsed;
        bit                            stopped;
        t_result                       expected_samples[$];
        int                            errors;

        function void clear();
            cfg.period_length     = RST_PERIOD;
            cfg.decay_gain        = RST_DECAY;
            cfg.output_level      = RST_LEVEL;
            cfg.silence_threshold = RST_THRESHOLD;
            cfg.hold_samples      = RST_HOLD;
            rd_pos      = '0;
            prev_sample = '0;
            elapsed     = '0;
            stopped     = 1'b0;
            errors      = 0;
        endfunction

        function int eff_period();
            int p;
            p = int'(cfg.period_length);
            if (p < 2) return 2;
            if (p > MAX_PERIOD) return MAX_PERIOD;
            return p;
        endfunction

        function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [APB_DATA_BITS-1:0] value);
            case (idx)
                REG_PERIOD:    cfg.period_length     = value[PERIOD_BITS-1:0];
                REG_DECAY:     cfg.decay_gain        = value[GAIN_BITS-1:0];
                REG_LEVEL:     cfg.output_level      = value[GAIN_BITS-1:0];
                REG_THRESHOLD: cfg.silence_threshold = value[THR_BITS-1:0];
                REG_HOLD:      cfg.hold_samples      = value[HOLD_BITS-1:0];
                default: ;
            endcase
        endfunction

        function logic [APB_DATA_BITS-1:0] reg_value(logic [CFG_IDX_BITS-1:0] idx);
            case (idx)
                REG_PERIOD:    return APB_DATA_BITS'(cfg.period_length);
                REG_DECAY:     return APB_DATA_BITS'(cfg.decay_gain);
                REG_LEVEL:     return APB_DATA_BITS'(cfg.output_level);
                REG_THRESHOLD: return APB_DATA_BITS'(cfg.silence_threshold);
                REG_HOLD:      return APB_DATA_BITS'(cfg.hold_samples);
                default:       return '0;
            endcase
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10) $display("%0t: %s", $time, msg);
        endfunction

        function void take_item(t_item it);
            longint  cur;
            longint  fb;
            longint  scaled;
            longint  mag;
            int      nxt;
            t_result r;
            if (it.func == FUNC_LOAD) begin
                delay_line[it.entry_index] = it.excitation;
                prev_sample = '0;
                rd_pos      = '0;
                elapsed     = '0;
                stopped     = 1'b0;
                return;
            end
            if (stopped) begin
                r.sample_out = '0;
                r.active     = 1'b0;
                expected_samples.push_back(r);
                return;
            end
            cur    = longint'(delay_line[rd_pos]);
            fb     = ((cur + longint'(prev_sample)) * longint'(cfg.decay_gain)) / 131072;
            scaled = (cur * longint'(cfg.output_level)) / 65536;
            mag    = (cur < 0) ? -cur : cur;
            delay_line[rd_pos] = fb[SAMPLE_BITS-1:0];
            prev_sample = cur[SAMPLE_BITS-1:0];
            // a position left beyond a shortened period wraps on its next step
            nxt    = int'(rd_pos) + 1;
            rd_pos = (nxt >= eff_period()) ? '0 : nxt[ADDR_BITS-1:0];
            if (elapsed > cfg.hold_samples && mag < longint'(cfg.silence_threshold))
                stopped = 1'b1;
            if (elapsed != ELAPSED_MAX)
                elapsed++;
            r.sample_out = scaled[SAMPLE_BITS-1:0];
            r.active     = !stopped;
            expected_samples.push_back(r);
        endfunction

        function void check_sample(logic signed [SAMPLE_BITS-1:0] s, logic a);
            t_result r;
            if (expected_samples.size() == 0) begin
                flag($sformatf("unexpected result: sample_out %0d active %0b", s, a));
                return;
            end
            r = expected_samples.pop_front();
            if (s !== r.sample_out || a !== r.active)
                flag($sformatf("result mismatch: expected sample_out %0d active %0b, got %0d %0b",
                               r.sample_out, r.active, s, a));
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [CFG_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    pss_in_if  item_if ();
    pss_out_if res_if ();

    voice_scoreboard sb;
    bit              written [MAX_PERIOD];
    int              burst_left;
    int              items_sent;
    bit              long_hold_req;
    t_rx_mode        rx_mode;
    int              rx_left;
    int              rx_hold;
    int              rx_cycle;

    plucked_string_synth_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (item_if),
        .o_out   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("plucked_string_synth_core regression: fail");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready)
            sb.check_sample(res_if.sample_out, res_if.active);
    end

    // Result side: random stall modes, plus a long hold-off on request.
    initial begin
        res_if.ready = 1'b0;
        rx_left  = 0;
        rx_hold  = 0;
        rx_cycle = 0;
        rx_mode  = RX_OPEN;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                rx_hold = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                res_if.ready <= 1'b0;
            end else begin
                if (rx_left == 0) begin
                    rx_mode = t_rx_mode'($urandom_range(0, 3));
                    rx_left = $urandom_range(16, 80);
                end
                rx_left--;
                rx_cycle++;
                case (rx_mode)
                    RX_OPEN:   res_if.ready <= 1'b1;
                    RX_COIN:   res_if.ready <= 1'($urandom_range(0, 1));
                    RX_THIRD:  res_if.ready <= (rx_cycle % 3 == 0);
                    RX_MOSTLY: res_if.ready <= ($urandom_range(0, 7) != 0);
                    default:   res_if.ready <= 1'b1;
                endcase
            end
        end
    end

    task automatic send_item(input logic f, input logic [ADDR_BITS-1:0] idx,
                             input logic signed [SAMPLE_BITS-1:0] x);
        int    gap;
        t_item it;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge i_clk);
                item_if.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        item_if.valid       <= 1'b1;
        item_if.func        <= f;
        item_if.entry_index <= idx;
        item_if.excitation  <= x;
        do @(posedge i_clk); while (!item_if.ready);
        it.func        = f;
        it.entry_index = idx;
        it.excitation  = x;
        sb.take_item(it);
        items_sent++;
    endtask

    // Drop valid and wait for the voice to go quiet.
    task automatic settle();
        @(negedge i_clk);
        item_if.valid <= 1'b0;
        burst_left = 0;
        while (sb.expected_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [APB_DATA_BITS-1:0] value);
        logic [APB_DATA_BITS-1:0] rd;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, value);
        // read back the same register
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        if (rd !== sb.reg_value(idx))
            sb.flag($sformatf("register %0d readback: expected 0x%0h, got 0x%0h",
                              idx, sb.reg_value(idx), rd));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        logic signed [SAMPLE_BITS-1:0] v;
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: begin
                v = SAMPLE_BITS'($urandom_range(0, 64));
                return v - 16'sd32;
            end
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    task automatic load_entry(input int idx, input logic signed [SAMPLE_BITS-1:0] x);
        send_item(FUNC_LOAD, ADDR_BITS'(idx), x);
        written[idx] = 1'b1;
    endtask

    // Never let a tick read an entry that has not been loaded.
    task automatic tick_once();
        while (!sb.stopped && !written[sb.rd_pos])
            load_entry(int'(sb.rd_pos), rand_sample());
        send_item(FUNC_TICK, ADDR_BITS'($urandom_range(0, MAX_PERIOD - 1)),
                  SAMPLE_BITS'($urandom));
    endtask

    task automatic pluck();
        int p;
        int n;
        int nload;
        bit down;
        p = sb.eff_period();
        n = (p <= 64) ? $urandom_range(p, 3 * p) : $urandom_range(10, 60);
        if (n > 90) n = 90;
        nload = (p <= 64) ? p : n + 1;
        down  = 1'($urandom_range(0, 1));
        for (int i = 0; i < nload; i++)
            load_entry(down ? nload - 1 - i : i, rand_sample());
        repeat (n) tick_once();
    endtask

    task automatic scatter_loads();
        repeat ($urandom_range(1, 6))
            load_entry($urandom_range(0, MAX_PERIOD - 1), SAMPLE_BITS'($urandom));
        repeat ($urandom_range(1, 12)) tick_once();
    endtask

    task automatic configure(input int phase);
        logic [APB_DATA_BITS-1:0] p, d, l, t, h;
        settle();
        case (phase)
            0: begin p = 0;    d = 65535; l = 0;     t = 0;     h = 1048575; end
            1: begin p = 1024; d = 0;     l = 65535; t = 32767; h = 0;       end
            2: begin p = 2047; d = 65535; l = 65535; t = 0;     h = 0;       end
            3: begin p = 2;    d = 0;     l = 0;     t = 32767; h = 1048575; end
            default: begin
                case ($urandom_range(0, 9))
                    0:       p = 0;
                    1:       p = 1;
                    2:       p = 1024;
                    default: p = $urandom_range(2, 40);
                endcase
                case ($urandom_range(0, 3))
                    0:       d = 0;
                    1:       d = 65535;
                    2:       d = $urandom_range(60000, 65535);
                    default: d = $urandom_range(0, 65535);
                endcase
                case ($urandom_range(0, 3))
                    0:       l = 0;
                    1:       l = 65535;
                    default: l = $urandom_range(0, 65535);
                endcase
                case ($urandom_range(0, 3))
                    0:       t = 0;
                    1:       t = 32767;
                    default: t = $urandom_range(1, 3000);
                endcase
                case ($urandom_range(0, 3))
                    0:       h = 0;
                    1:       h = 1048575;
                    default: h = $urandom_range(0, 150);
                endcase
            end
        endcase
        write_reg(REG_PERIOD, p);
        write_reg(REG_DECAY, d);
        write_reg(REG_LEVEL, l);
        write_reg(REG_THRESHOLD, t);
        write_reg(REG_HOLD, h);
    endtask

    task automatic run_phase(input int phase);
        int nseg;
        int kind;
        nseg = $urandom_range(3, 6);
        // on a coin toss, keep ticking from where the last phase left the read position
        if ($urandom_range(0, 1)) repeat ($urandom_range(1, 20)) tick_once();
        for (int s = 0; s < nseg; s++) begin
            if ((phase == 1 || phase == 5) && s == 1) long_hold_req = 1'b1;
            kind = $urandom_range(0, 9);
            if (kind < 6) pluck();
            else if (kind < 8) repeat ($urandom_range(1, 40)) tick_once();
            else scatter_loads();
        end
    endtask

    initial begin
        int phase;
        int first;
        sb = new;
        sb.clear();
        i_rst_n             = 1'b0;
        item_if.valid       = 1'b0;
        item_if.func        = FUNC_LOAD;
        item_if.entry_index = '0;
        item_if.excitation  = '0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        burst_left          = 0;
        items_sent          = 0;
        long_hold_req       = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: extreme samples and the top index
        load_entry(0, 16'sh8000);
        load_entry(1, 16'sh7FFF);
        load_entry(2, 16'sh0000);
        load_entry(3, -16'sd1);
        load_entry(MAX_PERIOD - 1, 16'sh5555);
        load_entry(4, 16'sd1);
        repeat (5) tick_once();

        // period below two, full gains, immediate stop, then restart
        settle();
        write_reg(REG_PERIOD, 1);
        write_reg(REG_DECAY, 65535);
        write_reg(REG_LEVEL, 65535);
        write_reg(REG_THRESHOLD, 32767);
        write_reg(REG_HOLD, 0);
        load_entry(0, 16'sh8000);
        load_entry(1, 16'sd100);
        repeat (4) tick_once();
        load_entry(0, 16'sd7);
        repeat (2) tick_once();

        first = items_sent;
        phase = 0;
        while (items_sent - first < RANDOM_ITEMS) begin
            configure(phase);
            run_phase(phase);
            phase++;
        end

        settle();
        if (sb.errors == 0)
            $display("plucked_string_synth_core regression: pass");
        else
            $display("plucked_string_synth_core regression: fail");
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/pss_pkg.sv
hw/rtl/pss_if.sv
hw/rtl/pss_ram.sv
hw/rtl/pss_cfg.sv
hw/rtl/pss_voice.sv
hw/rtl/pss_obuf.sv
hw/rtl/plucked_string_synth_core.sv
tb/tb_plucked_string_synth_core.sv
